// ===== hdl/sct_pkg.sv =====
package sct_pkg;

   // Link table geometry
   localparam int NUM_SECTORS = 4096;
   localparam int SECT_W      = $clog2(NUM_SECTORS);
   localparam int ENTRY_W     = SECT_W + 1;
   localparam int CSR_W       = 13;

   typedef logic [SECT_W-1:0]  sect_type;
   typedef logic [ENTRY_W-1:0] entry_type;
   typedef logic [CSR_W-1:0]   lim_type;

   localparam entry_type END_MARK = '1;
   localparam entry_type FREE     = '0;

   // Request kinds
   localparam logic [2:0] KIND_START   = 3'd0;
   localparam logic [2:0] KIND_APPEND  = 3'd1;
   localparam logic [2:0] KIND_NEXT    = 3'd2;
   localparam logic [2:0] KIND_TRUNC   = 3'd3;
   localparam logic [2:0] KIND_RELEASE = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_END    = 2'd2;
   localparam logic [1:0] ST_BROKEN = 2'd3;

   // One cycle of link RAM traffic: one write, one read
   typedef struct packed {
      logic      we;
      sect_type  waddr;
      entry_type wdata;
      sect_type  raddr;
   } mem_req_type;

   // Finished request result
   typedef struct packed {
      logic       valid;
      sect_type   sector;
      logic [1:0] status;
   } result_type;

endpackage

// ===== hdl/sct_link_ram.sv =====
module sct_link_ram
   import sct_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rdata
);

   entry_type mem [NUM_SECTORS];
   entry_type q_ff;

   // Write port, and a registered read that returns new data on a same-address write
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.we && (mem_req.waddr == mem_req.raddr)) begin
         q_ff <= mem_req.wdata;
      end else begin
         q_ff <= mem[mem_req.raddr];
      end
   end

   assign rdata = q_ff;

endmodule

// ===== hdl/sct_ctrl.sv =====
module sct_ctrl
   import sct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [2:0]  req_kind,
   input  sect_type    req_sector,
   input  lim_type     lim,
   input  entry_type   rdata,
   input  logic        take,
   output logic        busy,
   output mem_req_type mem_req,
   output result_type  done
);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_APP  = 3'd3;
   localparam logic [2:0] S_NEXT = 3'd4;
   localparam logic [2:0] S_WALK = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] kind_ff, kind_in;
   sect_type   sec_ff, sec_in;
   lim_type    scan_ff, scan_in;
   lim_type    chk_ff, chk_in;
   logic       chk_vld_ff, chk_vld_in;
   sect_type   act_ff, act_in;
   lim_type    steps_ff, steps_in;
   logic       first_ff, first_in;
   sect_type   res_ff, res_in;
   logic [1:0] stat_ff, stat_in;
   sect_type   clr_ff, clr_in;
   logic       accept;

   assign accept = req_valid && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      sec_in     = sec_ff;
      scan_in    = scan_ff;
      chk_in     = chk_ff;
      chk_vld_in = chk_vld_ff;
      act_in     = act_ff;
      steps_in   = steps_ff;
      first_in   = first_ff;
      res_in     = res_ff;
      stat_in    = stat_ff;
      clr_in     = clr_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = act_ff;
      mem_req.wdata = FREE;
      mem_req.raddr = act_ff;
      case (state_ff)
         // Sweep the table to free after reset
         S_CLR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         // Take a request and issue the read of its sector
         S_IDLE: begin
            mem_req.raddr = req_sector;
            if (accept) begin
               kind_in    = req_kind;
               sec_in     = req_sector;
               act_in     = req_sector;
               res_in     = '0;
               stat_in    = ST_OK;
               scan_in    = lim_type'(1);
               chk_vld_in = 1'b0;
               steps_in   = '0;
               first_in   = 1'b1;
               case (req_kind)
                  KIND_START, KIND_APPEND: state_in = S_SCAN;
                  KIND_NEXT:               state_in = S_NEXT;
                  KIND_TRUNC, KIND_RELEASE: state_in = S_WALK;
                  default:                 state_in = S_DONE;
               endcase
            end
         end
         // First-fit scan: one read issued and one entry checked per cycle
         S_SCAN: begin
            mem_req.raddr = scan_ff[SECT_W-1:0];
            if (chk_vld_ff && (chk_ff >= lim)) begin
               stat_in  = ST_FULL;
               state_in = S_DONE;
            end else if (chk_vld_ff && (rdata == FREE)) begin
               res_in     = chk_ff[SECT_W-1:0];
               mem_req.we = 1'b1;
               if (kind_ff == KIND_START) begin
                  mem_req.waddr = chk_ff[SECT_W-1:0];
                  mem_req.wdata = END_MARK;
                  state_in      = S_DONE;
               end else begin
                  mem_req.waddr = sec_ff;
                  mem_req.wdata = {1'b0, chk_ff[SECT_W-1:0]};
                  state_in      = S_APP;
               end
            end else begin
               scan_in    = scan_ff + 1'b1;
               chk_in     = scan_ff;
               chk_vld_in = 1'b1;
            end
         end
         // Mark the appended sector as the chain end
         S_APP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = res_ff;
            mem_req.wdata = END_MARK;
            state_in      = S_DONE;
         end
         // Decode the link of the given sector
         S_NEXT: begin
            if (rdata == END_MARK) begin
               stat_in = ST_END;
            end else if ((rdata == FREE) || rdata[SECT_W]) begin
               stat_in = ST_BROKEN;
            end else begin
               res_in = rdata[SECT_W-1:0];
            end
            state_in = S_DONE;
         end
         // Walk the chain: clear this entry and read the next in the same cycle
         S_WALK: begin
            if (first_ff && (rdata == FREE)) begin
               stat_in  = ST_BROKEN;
               state_in = S_DONE;
            end else if (rdata == END_MARK) begin
               mem_req.we = 1'b1;
               state_in   = S_FIN;
            end else if ((rdata == FREE) || rdata[SECT_W] || (steps_ff >= lim)) begin
               mem_req.we = 1'b1;
               stat_in    = ST_BROKEN;
               state_in   = S_FIN;
            end else begin
               mem_req.we    = 1'b1;
               mem_req.raddr = rdata[SECT_W-1:0];
               act_in        = rdata[SECT_W-1:0];
               steps_in      = steps_ff + 1'b1;
               first_in      = 1'b0;
            end
         end
         // Finish the head: end mark for truncate, free for release
         S_FIN: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = sec_ff;
            mem_req.wdata = (kind_ff == KIND_TRUNC) ? END_MARK : FREE;
            state_in      = S_DONE;
         end
         // Hold the result until the output register takes it
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      sec_ff     <= sec_in;
      scan_ff    <= scan_in;
      chk_ff     <= chk_in;
      chk_vld_ff <= chk_vld_in;
      act_ff     <= act_in;
      steps_ff   <= steps_in;
      first_ff   <= first_in;
      res_ff     <= res_in;
      stat_ff    <= stat_in;
   end

   assign done.valid  = (state_ff == S_DONE);
   assign done.sector = res_ff;
   assign done.status = stat_ff;

endmodule

// ===== hdl/sector_chain_table.sv =====
// Channel   | Ports                                       | Direction
// request   | req_valid, req_stall, req_kind, req_sector  | in (stall out)
// response  | rsp_valid, rsp_stall, rsp_result_sector,    | out (stall in)
//           | rsp_status                                  |
// csr       | csr_we, csr_wdata (sectors in use)          | in
//
// One request at a time; the link RAM read port paces every operation.
// Start and append scan for the first free sector from sector 1 (one entry per cycle);
// with no free sector below the limit they answer full. Next link reads the given sector's entry.
// Truncate/release walk the chain, clearing each entry as the next one is read.
// After reset a clearing pass writes all 4096 entries with req_stall high.
// A finished response waits in its own register, so a new request is taken under rsp_stall.
module sector_chain_table
   import sct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  sect_type    req_sector,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sect_type    rsp_result_sector,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  lim_type     csr_wdata
);

   lim_type     siu_ff;
   lim_type     lim;
   mem_req_type mem_req;
   entry_type   rdata;
   result_type  done;
   logic        take;
   logic        rsp_valid_ff;
   sect_type    rsp_sector_ff;
   logic [1:0]  rsp_status_ff;

   // Sectors-in-use register, clamped to the table size
   always_ff @(posedge clock) begin
      if (reset) begin
         siu_ff <= lim_type'(NUM_SECTORS);
      end else if (csr_we) begin
         siu_ff <= csr_wdata;
      end
   end

   assign lim = (siu_ff > lim_type'(NUM_SECTORS)) ? lim_type'(NUM_SECTORS) : siu_ff;

   sct_link_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   sct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_kind   (req_kind),
      .req_sector (req_sector),
      .lim        (lim),
      .rdata      (rdata),
      .take       (take),
      .busy       (req_stall),
      .mem_req    (mem_req),
      .done       (done)
   );

   // Output register: load when empty or draining, drop when taken
   assign take = done.valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_sector_ff <= done.sector;
         rsp_status_ff <= done.status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_sector = rsp_sector_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ===== hdl/sct_checker.sv =====
module sct_checker
   import sct_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input sect_type   rsp_result_sector,
   input logic [1:0] rsp_status
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_sector)
                                 && $stable(rsp_status))
      else $error("stalled response changed");

   // Drive sector zero on any status but ok
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_result_sector == '0)
      else $error("nonzero sector with failing status");

   // Stall the next request while one is in work
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Stall requests as the clearing pass starts after reset
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request port open after reset");

endmodule

bind sector_chain_table sct_checker u_sct_checker (.*);

// ===== dv/tb.sv =====
module tb;
   import sct_pkg::*;

   // Kinds outside the defined set; the block answers them with ok and no change
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int MAX_CHAINS  = 40;
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [2:0] kind;
      sect_type   req_sector;
      sect_type   sector;
      logic [1:0] status;
   } link_answer_type;

   logic      clock      = 1'b0;
   logic      reset      = 1'b1;
   logic      req_valid  = 1'b0;
   logic      req_stall;
   logic [2:0] req_kind  = KIND_START;
   sect_type  req_sector = '0;
   logic      rsp_valid;
   logic      rsp_stall  = 1'b0;
   sect_type  rsp_result_sector;
   logic [1:0] rsp_status;
   logic      csr_we     = 1'b0;
   lim_type   csr_wdata  = '0;

   // Predicted link table and sectors-in-use register
   entry_type link_mem [NUM_SECTORS];
   lim_type   sectors_limit;

   link_answer_type pending_answers[$];
   link_answer_type oldest_answer;

   // Chains the random traffic knows about
   sect_type  chain_head[$];
   sect_type  chain_tail[$];
   sect_type  walk_cursor = '0;
   bit        last_full   = 1'b0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_left      = 0;
   int unsigned cycle_count    = 0;
   int          error_count    = 0;
   int          requests_sent  = 0;
   int          responses_checked = 0;
   int          status_seen [4] = '{0, 0, 0, 0};

   sector_chain_table i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_sector        (req_sector),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_sector (rsp_result_sector),
      .rsp_status        (rsp_status),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // Walks and scans stop at the smaller of the register and the table size
   function automatic int walk_bound();
      return (sectors_limit > NUM_SECTORS) ? NUM_SECTORS : int'(sectors_limit);
   endfunction

   // First-fit scan from sector 1
   function automatic bit first_free(output sect_type found);
      int bound;
      bound = walk_bound();
      found = '0;
      for (int i = 1; i < bound; i++) begin
         if (link_mem[i] == FREE) begin
            found = sect_type'(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Clear the chain behind head, then finish the head with head_val
   function automatic logic [1:0] clear_chain(sect_type head, entry_type head_val);
      int         bound;
      int         steps;
      sect_type   cur;
      entry_type  nxt;
      logic [1:0] st;
      bound = walk_bound();
      steps = 0;
      cur   = head;
      st    = ST_OK;
      if (link_mem[head] == FREE) return ST_BROKEN;
      forever begin
         nxt = link_mem[cur];
         if (nxt == END_MARK) break;
         if (nxt == FREE || nxt >= NUM_SECTORS || steps >= bound) begin
            st = ST_BROKEN;
            break;
         end
         link_mem[cur] = FREE;
         cur = nxt[SECT_W-1:0];
         steps++;
      end
      link_mem[cur]  = FREE;
      link_mem[head] = head_val;
      return st;
   endfunction

   // Apply one request to the predicted table and return its answer
   function automatic link_answer_type predict_answer(logic [2:0] kind, sect_type sector);
      link_answer_type ans;
      sect_type        found;
      entry_type       e;
      ans.kind       = kind;
      ans.req_sector = sector;
      ans.sector     = '0;
      ans.status     = ST_OK;
      case (kind)
         KIND_START: begin
            if (first_free(found)) begin
               link_mem[found] = END_MARK;
               ans.sector = found;
            end else begin
               ans.status = ST_FULL;
            end
         end
         KIND_APPEND: begin
            if (first_free(found)) begin
               link_mem[sector] = entry_type'(found);
               link_mem[found]  = END_MARK;
               ans.sector = found;
            end else begin
               ans.status = ST_FULL;
            end
         end
         KIND_NEXT: begin
            e = link_mem[sector];
            if (e == END_MARK) ans.status = ST_END;
            else if (e == FREE || e >= NUM_SECTORS) ans.status = ST_BROKEN;
            else ans.sector = e[SECT_W-1:0];
         end
         KIND_TRUNC:   ans.status = clear_chain(sector, END_MARK);
         KIND_RELEASE: ans.status = clear_chain(sector, FREE);
         default: ;
      endcase
      return ans;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < MAX_REPORTS)
         $display("MISMATCH at cycle %0d: %s: got %0d, expected %0d",
                  cycle_count, what, got, want);
      error_count++;
   endtask

   // Offer one request, hold it until taken, then record its expected answer
   task automatic send_request(input logic [2:0] kind, input sect_type sector,
                               output link_answer_type ans);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_sector <= sector;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ans = predict_answer(kind, sector);
      pending_answers.push_back(ans);
      requests_sent++;
   endtask

   // Drop valid and wait until every request is answered
   task automatic wait_idle(int settle);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_limit(lim_type value);
      wait_idle(16);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      sectors_limit = value;
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Receiver: long hold when asked, else random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Compare each taken response with the oldest expected answer
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("response with no request waiting", rsp_result_sector, 0);
         end else begin
            oldest_answer = pending_answers.pop_front();
            responses_checked++;
            status_seen[oldest_answer.status]++;
            if (rsp_result_sector !== oldest_answer.sector)
               report_mismatch($sformatf("result_sector, kind %0d sector %0d",
                               oldest_answer.kind, oldest_answer.req_sector),
                               rsp_result_sector, oldest_answer.sector);
            if (rsp_status !== oldest_answer.status)
               report_mismatch($sformatf("status, kind %0d sector %0d",
                               oldest_answer.kind, oldest_answer.req_sector),
                               rsp_status, oldest_answer.status);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d requests unanswered",
                  cycle_count, pending_answers.size());
         $display("** sector_chain_table: FAILED **");
         $finish;
      end
   end

   // Free entries, one chain built, read, truncated, released; spare kinds
   task automatic test_directed_links();
      link_answer_type ans;
      sect_type        head;
      sect_type        mid;
      sect_type        tail;
      send_request(KIND_NEXT, '0, ans);
      send_request(KIND_RELEASE, sect_type'(NUM_SECTORS - 1), ans);
      send_request(KIND_START, '0, ans);
      head = ans.sector;
      send_request(KIND_APPEND, head, ans);
      mid = ans.sector;
      send_request(KIND_APPEND, mid, ans);
      tail = ans.sector;
      send_request(KIND_NEXT, head, ans);
      send_request(KIND_NEXT, tail, ans);
      send_request(KIND_TRUNC, head, ans);
      send_request(KIND_SPARE_LO, sect_type'(NUM_SECTORS - 1), ans);
      send_request(KIND_SPARE_HI, '0, ans);
      // append after a sector that owns no chain
      send_request(KIND_APPEND, sect_type'(NUM_SECTORS - 1), ans);
      send_request(KIND_RELEASE, head, ans);
      send_request(KIND_RELEASE, sect_type'(NUM_SECTORS - 1), ans);
   endtask

   // Exhaust a tiny table, then a limit that leaves nothing to allocate
   task automatic test_no_free_sector();
      link_answer_type ans;
      sect_type        head;
      write_limit(lim_type'(3));
      send_request(KIND_START, '1, ans);
      head = ans.sector;
      send_request(KIND_START, '1, ans);
      send_request(KIND_START, '1, ans);
      send_request(KIND_APPEND, head, ans);
      write_limit(lim_type'(1));
      send_request(KIND_START, '0, ans);
   endtask

   // Release a chain longer than the walk limit
   task automatic test_walk_limit();
      link_answer_type ans;
      sect_type        head;
      sect_type        tail;
      write_limit(lim_type'(4096));
      send_request(KIND_START, '0, ans);
      head = ans.sector;
      tail = head;
      repeat (4) begin
         send_request(KIND_APPEND, tail, ans);
         tail = ans.sector;
      end
      write_limit(lim_type'(3));
      send_request(KIND_RELEASE, head, ans);
   endtask

   // Release a chain whose second link was freed underneath it
   task automatic test_broken_chain();
      link_answer_type ans;
      sect_type        head;
      sect_type        mid;
      write_limit(lim_type'(4096));
      send_request(KIND_START, '0, ans);
      head = ans.sector;
      send_request(KIND_APPEND, head, ans);
      mid = ans.sector;
      send_request(KIND_RELEASE, mid, ans);
      send_request(KIND_RELEASE, head, ans);
   endtask

   // Mostly well-formed chain traffic with some noise mixed in
   task automatic run_random_phase(int count);
      link_answer_type ans;
      logic [2:0]      kind;
      sect_type        sector;
      int              done;
      int              pick;
      int              idx;
      int              span;
      bit              listed;
      done = 0;
      while (done < count) begin
         pick   = $urandom_range(99);
         idx    = (chain_head.size() > 0) ? $urandom_range(chain_head.size() - 1) : 0;
         span   = (walk_bound() > 1) ? walk_bound() - 1 : 1;
         sector = sect_type'($urandom_range(NUM_SECTORS - 1));
         listed = 1'b0;
         if (pick < 12) begin
            kind = 3'($urandom_range(7));
            if ($urandom_range(1)) sector = sect_type'($urandom_range(span));
         end else if (chain_head.size() == 0 && last_full) begin
            // table looks full of orphans: free something low
            kind   = KIND_RELEASE;
            sector = sect_type'($urandom_range(span, 1));
         end else if (chain_head.size() == 0 || (pick < 30 && chain_head.size() < MAX_CHAINS)) begin
            kind = KIND_START;
         end else if (pick < 30 || pick >= 88) begin
            kind   = KIND_RELEASE;
            sector = chain_head[idx];
            listed = 1'b1;
         end else if (pick < 58) begin
            kind   = KIND_APPEND;
            sector = chain_tail[idx];
            listed = 1'b1;
         end else if (pick < 75) begin
            kind   = KIND_NEXT;
            sector = walk_cursor;
         end else begin
            kind   = KIND_TRUNC;
            sector = chain_head[idx];
            listed = 1'b1;
         end

         send_request(kind, sector, ans);
         if (kind <= KIND_RELEASE) done++;
         last_full = (ans.status == ST_FULL);

         // track the chains as the prediction says they now stand
         case (kind)
            KIND_START: begin
               if (ans.status == ST_OK) begin
                  chain_head.push_back(ans.sector);
                  chain_tail.push_back(ans.sector);
               end
            end
            KIND_APPEND: begin
               if (listed && ans.status == ST_OK) chain_tail[idx] = ans.sector;
            end
            KIND_NEXT: begin
               if (ans.status == ST_OK) walk_cursor = ans.sector;
               else if (chain_head.size() > 0) walk_cursor = chain_head[idx];
            end
            KIND_TRUNC: begin
               if (listed) chain_tail[idx] = chain_head[idx];
            end
            KIND_RELEASE: begin
               if (listed) begin
                  chain_head.delete(idx);
                  chain_tail.delete(idx);
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic test_random_traffic();
      set_idling(37, 85);
      write_limit(lim_type'(4096));
      run_random_phase(500);
      set_idling(85, 37);
      write_limit(lim_type'(48));
      run_random_phase(450);
      set_idling(0, 0);
      write_limit(lim_type'(8191));
      run_random_phase(450);
      write_limit(lim_type'(5));
      run_random_phase(200);
      write_limit(lim_type'(0));
      run_random_phase(30);
      write_limit(lim_type'(2));
      run_random_phase(60);
   endtask

   // Hold the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      set_idling(0, 0);
      write_limit(lim_type'(64));
      hold_left = 400;
      run_random_phase(40);
      wait_idle(16);
   endtask

   initial begin
      foreach (link_mem[i]) link_mem[i] = FREE;
      sectors_limit = lim_type'(4096);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // wait out the clearing pass
      while (req_stall !== 1'b0) @(posedge clock);

      write_limit(lim_type'(4096));
      test_directed_links();
      test_no_free_sector();
      test_walk_limit();
      test_broken_chain();
      test_random_traffic();
      test_backpressure();
      wait_idle(64);

      $display("Run covered %0d requests and %0d checked responses over limits 0 to 8191.",
               requests_sent, responses_checked);
      $display("Statuses seen: ok %0d, no free sector %0d, end of chain %0d, broken %0d.",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_END],
               status_seen[ST_BROKEN]);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("** sector_chain_table: PASSED **");
      end else begin
         $display("** sector_chain_table: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sector_chain_table.f =====
hdl/sct_pkg.sv
hdl/sct_link_ram.sv
hdl/sct_ctrl.sv
hdl/sector_chain_table.sv
hdl/sct_checker.sv
dv/tb.sv
